[sv/block_allocator_bitmap_assert.svh]
// ============================================================================
// Assertion macros for the bitmap block allocator
// Concurrent checks on clk with rst_n, empty bodies for synthesis.
// ============================================================================
`ifndef BLOCK_ALLOCATOR_BITMAP_ASSERT_SVH
`define BLOCK_ALLOCATOR_BITMAP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define BAB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block_allocator_bitmap: check failed");
// Next-cycle implication.
`define BAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block_allocator_bitmap: check failed");
`else
`define BAB_ASSERT_NOW(lbl, ante, cons)
`define BAB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/bab_pkg.sv]
// ============================================================================
// bab_pkg
// Shared widths, codes, reset values and scan types of the block allocator.
// ============================================================================
package bab_pkg;

    localparam int BLK_W          = 12;   // block number width
    localparam int WORD_W         = 32;   // blocks per memory word
    localparam int BIT_W          = 5;    // bit position inside a word
    localparam int WIDX_W         = BLK_W - BIT_W;
    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int MAP_SKIP       = 2;    // leading partition blocks outside the map

    localparam logic [BLK_W-1:0] FIRST_RST = 12'd0;
    localparam logic [BLK_W-1:0] LAST_RST  = 12'd1759;
    localparam logic [BLK_W-1:0] ROOT_RST  = 12'd880;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_CLAIM   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_FIRST = 2'd0,
        REG_LAST  = 2'd1,
        REG_ROOT  = 2'd2
    } reg_idx_t;

    // One scan phase: block window [lo, hi], walked downward when down is set.
    typedef struct packed {
        logic             down;
        logic [BLK_W-1:0] lo;
        logic [BLK_W-1:0] hi;
    } scan_req_t;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] blk;
    } scan_res_t;

endpackage

[sv/bab_scan.sv]
// ============================================================================
// bab_scan
// Word search: first empty block of one occupancy word inside the window.
// ============================================================================
module bab_scan (
    input  bab_pkg::scan_req_t               req,
    input  logic [bab_pkg::WIDX_W-1:0]       widx,
    input  logic [bab_pkg::WORD_W-1:0]       occ,
    output bab_pkg::scan_res_t               res
);

    logic [bab_pkg::WORD_W-1:0] ones;
    logic [bab_pkg::WORD_W-1:0] lo_mask;
    logic [bab_pkg::WORD_W-1:0] hi_mask;
    logic [bab_pkg::WORD_W-1:0] cand;
    logic [bab_pkg::WORD_W-1:0] rev;
    logic [bab_pkg::WORD_W-1:0] pick;
    logic [bab_pkg::WORD_W-1:0] iso;
    logic [bab_pkg::BIT_W-1:0]  pos;
    logic [bab_pkg::BIT_W-1:0]  bitn;

    always_comb
    begin
        ones    = '1;
        // trim the window at its end words
        lo_mask = (widx == req.lo[bab_pkg::BLK_W-1:bab_pkg::BIT_W])
                ? (ones << req.lo[bab_pkg::BIT_W-1:0]) : ones;
        hi_mask = (widx == req.hi[bab_pkg::BLK_W-1:bab_pkg::BIT_W])
                ? (ones >> (~req.hi[bab_pkg::BIT_W-1:0])) : ones;
        cand    = ~occ & lo_mask & hi_mask;

        // mirror for a downward walk so both take the lowest set bit
        for (int i = 0; i < bab_pkg::WORD_W; i++)
        begin
            rev[i] = cand[bab_pkg::WORD_W-1-i];
        end
        pick = req.down ? rev : cand;
        iso  = pick & (~pick + bab_pkg::WORD_W'(1));

        pos = '0;
        for (int i = 0; i < bab_pkg::WORD_W; i++)
        begin
            if (iso[i])
            begin
                pos = pos | bab_pkg::BIT_W'(i);
            end
        end
        bitn = req.down ? ~pos : pos;

        res.found = |cand;
        res.blk   = {widx, bitn};
    end

endmodule

[sv/block_allocator_bitmap.sv]
// ============================================================================
// block_allocator_bitmap
// First-fit bitmap block allocator: occupancy and free map in one memory.
// ============================================================================
//
//  Channel   Ports                                         Transfer
//  --------  --------------------------------------------  ---------------------
//  command   start, busy, action, block_nr                 start && !busy
//  result    done, granted_block, is_free, in_range        one cycle on done
//  config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready tied high
//
//  Release, query and claim read their map word in S_RD; in S_MOD release
//  and claim write it back and all three answer. A block number past the end
//  answers at once. Allocate reads 32-block words until an empty block turns
//  up, above the root first and then below it; the single read port of the
//  map memory, one word a cycle, paces the search. An allocate with both
//  search windows empty answers without reading the map.
//  After reset a clearing pass writes every map word (128 at the default)
//  while busy stays high; config writes are taken.
//  A new transaction is taken in the cycle its predecessor's result shows.
//
module block_allocator_bitmap #(
    parameter int NUM_BLOCKS = bab_pkg::NUM_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [bab_pkg::BLK_W-1:0]   block_nr,
    // result channel
    output logic                        done,
    output logic [bab_pkg::BLK_W-1:0]   granted_block,
    output logic                        is_free,
    output logic                        in_range,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int BLK_W  = bab_pkg::BLK_W;
    localparam int WORD_W = bab_pkg::WORD_W;
    localparam int BIT_W  = bab_pkg::BIT_W;
    localparam int WIDX_W = bab_pkg::WIDX_W;
    localparam int NWORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int MEM_AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int NB_W   = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W  = (NB_W > BLK_W) ? NB_W : BLK_W + 1;

    localparam logic [CMP_W-1:0]  NB_V    = CMP_W'(NUM_BLOCKS);
    localparam logic [BLK_W-1:0]  TOP_CAP = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [MEM_AW-1:0] CLR_END = MEM_AW'(NWORDS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_MOD,
        S_SCAN
    } state_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [BLK_W-1:0] first_reg;
    logic [BLK_W-1:0] last_reg;
    logic [BLK_W-1:0] root_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= bab_pkg::FIRST_RST;
            last_reg  <= bab_pkg::LAST_RST;
            root_reg  <= bab_pkg::ROOT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (bab_pkg::reg_idx_t'(paddr[3:2]))
                bab_pkg::REG_FIRST: first_reg <= pwdata[BLK_W-1:0];
                bab_pkg::REG_LAST:  last_reg  <= pwdata[BLK_W-1:0];
                bab_pkg::REG_ROOT:  root_reg  <= pwdata[BLK_W-1:0];
                default:            ;   // no register here, drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (bab_pkg::reg_idx_t'(paddr[3:2]))
            bab_pkg::REG_FIRST: prdata = 32'(first_reg);
            bab_pkg::REG_LAST:  prdata = 32'(last_reg);
            bab_pkg::REG_ROOT:  prdata = 32'(root_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Block classification
    // ------------------------------------------------------------------------
    function automatic logic blk_in_range(input logic [BLK_W-1:0] b);
        return CMP_W'(b) < NB_V;
    endfunction

    // Blocks outside the map always read as not free; their free bit is frozen.
    function automatic logic blk_in_map(input logic [BLK_W-1:0] b,
                                        input logic [BLK_W-1:0] lo,
                                        input logic [BLK_W-1:0] hi);
        logic [BLK_W:0] b_x;
        logic [BLK_W:0] min_x;
        b_x   = {1'b0, b};
        min_x = {1'b0, lo} + (BLK_W+1)'(bab_pkg::MAP_SKIP);
        return blk_in_range(b) && (b <= hi) && (b_x >= min_x);
    endfunction

    // ------------------------------------------------------------------------
    // Search windows, derived from the live config at command accept
    // ------------------------------------------------------------------------
    logic [BLK_W-1:0] top_blk;
    logic [BLK_W-1:0] up_lo;
    logic             up_empty;
    logic [BLK_W-1:0] dn_raw;
    logic [BLK_W-1:0] dn_hi;
    logic [BLK_W-1:0] dn_lo;
    logic             dn_empty;

    always_comb
    begin
        top_blk  = (CMP_W'(last_reg) < NB_V) ? last_reg : TOP_CAP;
        up_lo    = root_reg + BLK_W'(1);
        up_empty = root_reg >= top_blk;
        dn_raw   = root_reg - BLK_W'(1);
        dn_hi    = (CMP_W'(dn_raw) < NB_V) ? dn_raw : TOP_CAP;
        // block zero is never handed out
        dn_lo    = (first_reg == '0) ? BLK_W'(1) : first_reg;
        dn_empty = (root_reg <= first_reg) || (dn_hi < dn_lo);
    end

    // ------------------------------------------------------------------------
    // Map memory: word = {free bits, occupied bits} of 32 blocks
    // ------------------------------------------------------------------------
    logic [2*WORD_W-1:0] map_mem [NWORDS];
    logic [2*WORD_W-1:0] rdata_reg;
    logic                mem_rd_en;
    logic [MEM_AW-1:0]   mem_rd_addr;
    logic                mem_wr_en;
    logic [MEM_AW-1:0]   mem_wr_addr;
    logic [2*WORD_W-1:0] mem_wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            map_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= map_mem[mem_rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    state_t             state_reg,   state_next;
    bab_pkg::action_t   act_reg,     act_next;
    logic [BLK_W-1:0]   blk_reg,     blk_next;
    bab_pkg::scan_req_t req_reg,     req_next;
    logic [BLK_W-1:0]   dn_lo_reg,   dn_lo_next;
    logic [BLK_W-1:0]   dn_hi_reg,   dn_hi_next;
    logic               dn_ok_reg,   dn_ok_next;
    logic [WIDX_W-1:0]  rd_w_reg,    rd_w_next;
    logic               rd_more_reg, rd_more_next;
    logic               chk_v_reg,   chk_v_next;
    logic [WIDX_W-1:0]  chk_w_reg,   chk_w_next;
    logic [MEM_AW-1:0]  clr_reg,     clr_next;
    logic               done_reg,    done_next;
    logic [BLK_W-1:0]   granted_reg, granted_next;
    logic               free_reg,    free_next;
    logic               rng_reg,     rng_next;

    bab_pkg::scan_res_t scan_res;
    logic [BLK_W-1:0]   tgt_blk;
    logic [WORD_W-1:0]  tgt_oh;
    logic [WORD_W-1:0]  free_oh;
    logic               tgt_map;
    logic [WORD_W-1:0]  occ_w;
    logic [WORD_W-1:0]  free_w;
    logic [WIDX_W-1:0]  end_w;

    bab_scan u_scan (
        .req  (req_reg),
        .widx (chk_w_reg),
        .occ  (rdata_reg[WORD_W-1:0]),
        .res  (scan_res)
    );

    assign occ_w   = rdata_reg[WORD_W-1:0];
    assign free_w  = rdata_reg[2*WORD_W-1:WORD_W];
    // target of a write-back: the found block while scanning, else the command's
    assign tgt_blk = (state_reg == S_SCAN) ? scan_res.blk : blk_reg;
    assign tgt_oh  = WORD_W'(1) << tgt_blk[BIT_W-1:0];
    assign tgt_map = blk_in_map(tgt_blk, first_reg, last_reg);
    assign free_oh = tgt_map ? tgt_oh : '0;
    assign end_w   = req_reg.down ? req_reg.lo[BLK_W-1:BIT_W] : req_reg.hi[BLK_W-1:BIT_W];

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        blk_next     = blk_reg;
        req_next     = req_reg;
        dn_lo_next   = dn_lo_reg;
        dn_hi_next   = dn_hi_reg;
        dn_ok_next   = dn_ok_reg;
        rd_w_next    = rd_w_reg;
        rd_more_next = rd_more_reg;
        chk_v_next   = chk_v_reg;
        chk_w_next   = chk_w_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        free_next    = free_reg;
        rng_next     = rng_reg;

        mem_rd_en    = 1'b0;
        mem_rd_addr  = MEM_AW'(blk_reg[BLK_W-1:BIT_W]);
        mem_wr_en    = 1'b0;
        mem_wr_addr  = MEM_AW'(tgt_blk[BLK_W-1:BIT_W]);
        mem_wr_data  = rdata_reg;

        unique case (state_reg)
            S_CLR:
            begin
                // every block empty and free
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = {{WORD_W{1'b1}}, {WORD_W{1'b0}}};
                if (clr_reg == CLR_END)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + MEM_AW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next     = bab_pkg::action_t'(action);
                    blk_next     = block_nr;
                    granted_next = '0;
                    free_next    = 1'b0;
                    dn_lo_next   = dn_lo;
                    dn_hi_next   = dn_hi;
                    chk_v_next   = 1'b0;
                    rd_more_next = 1'b1;
                    if (bab_pkg::action_t'(action) == bab_pkg::ACT_ALLOC)
                    begin
                        rng_next = 1'b1;
                        if (!up_empty)
                        begin
                            req_next   = '{down: 1'b0, lo: up_lo, hi: top_blk};
                            rd_w_next  = up_lo[BLK_W-1:BIT_W];
                            dn_ok_next = !dn_empty;
                            state_next = S_SCAN;
                        end
                        else if (!dn_empty)
                        begin
                            req_next   = '{down: 1'b1, lo: dn_lo, hi: dn_hi};
                            rd_w_next  = dn_hi[BLK_W-1:BIT_W];
                            dn_ok_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else if (blk_in_range(block_nr))
                    begin
                        rng_next   = 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        // past the end of the store: answer at once
                        rng_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            S_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                case (act_reg) inside
                    bab_pkg::ACT_RELEASE:
                    begin
                        // only an occupied block changes
                        mem_wr_en   = |(occ_w & tgt_oh);
                        mem_wr_data = {free_w | free_oh, occ_w & ~tgt_oh};
                    end
                    bab_pkg::ACT_CLAIM:
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {free_w & ~free_oh, occ_w | tgt_oh};
                    end
                    bab_pkg::ACT_QUERY, bab_pkg::ACT_ALLOC:
                    begin
                        free_next = tgt_map && |(free_w & tgt_oh);
                    end
                    default:
                    begin
                        mem_wr_en = 1'b0;
                    end
                endcase
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // read the next word while checking the one read last cycle
                chk_v_next = rd_more_reg;
                chk_w_next = rd_w_reg;
                if (rd_more_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = MEM_AW'(rd_w_reg);
                    if (rd_w_reg == end_w)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_w_next = req_reg.down ? rd_w_reg - WIDX_W'(1)
                                                 : rd_w_reg + WIDX_W'(1);
                    end
                end

                if (chk_v_reg && scan_res.found)
                begin
                    // take the block: mark occupied, clear its free bit
                    mem_wr_en    = 1'b1;
                    mem_wr_data  = {free_w & ~free_oh, occ_w | tgt_oh};
                    granted_next = scan_res.blk;
                    chk_v_next   = 1'b0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (chk_v_reg && !rd_more_reg)
                begin
                    if (dn_ok_reg)
                    begin
                        // upward window exhausted, turn below the root
                        req_next     = '{down: 1'b1, lo: dn_lo_reg, hi: dn_hi_reg};
                        rd_w_next    = dn_hi_reg[BLK_W-1:BIT_W];
                        rd_more_next = 1'b1;
                        dn_ok_next   = 1'b0;
                        chk_v_next   = 1'b0;
                    end
                    else
                    begin
                        granted_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            act_reg     <= bab_pkg::ACT_ALLOC;
            blk_reg     <= '0;
            req_reg     <= '0;
            dn_lo_reg   <= '0;
            dn_hi_reg   <= '0;
            dn_ok_reg   <= 1'b0;
            rd_w_reg    <= '0;
            rd_more_reg <= 1'b0;
            chk_v_reg   <= 1'b0;
            chk_w_reg   <= '0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            granted_reg <= '0;
            free_reg    <= 1'b0;
            rng_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            blk_reg     <= blk_next;
            req_reg     <= req_next;
            dn_lo_reg   <= dn_lo_next;
            dn_hi_reg   <= dn_hi_next;
            dn_ok_reg   <= dn_ok_next;
            rd_w_reg    <= rd_w_next;
            rd_more_reg <= rd_more_next;
            chk_v_reg   <= chk_v_next;
            chk_w_reg   <= chk_w_next;
            clr_reg     <= clr_next;
            done_reg    <= done_next;
            granted_reg <= granted_next;
            free_reg    <= free_next;
            rng_reg     <= rng_next;
        end
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign granted_block = granted_reg;
    assign is_free       = free_reg;
    assign in_range      = rng_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "block_allocator_bitmap_assert.svh"

    // every accepted transaction either starts work or answers next cycle
    `BAB_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    // the scan never reads the word it is writing back
    `BAB_ASSERT_NOW(a_no_rw_clash, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
    // a rejected block number leaves a clean result
    `BAB_ASSERT_NOW(a_reject_clean, done && !in_range, granted_block == '0 && !is_free)

endmodule
